[rtl/lfj_pkg.sv]
package lfj_pkg;

	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_SQUAT  = 2'd1,
		PH_PUSH   = 2'd2,
		PH_AIR    = 2'd3
	} phase_t;

	// Register indexes on the write port
	localparam logic [2:0] REG_FORCE_LIMIT   = 3'd0;
	localparam logic [2:0] REG_NORMAL_TARGET = 3'd1;
	localparam logic [2:0] REG_NORMAL_STIFF  = 3'd2;
	localparam logic [2:0] REG_NORMAL_DAMP   = 3'd3;
	localparam logic [2:0] REG_FEEDFORWARD   = 3'd4;
	localparam logic [2:0] REG_PUSH_FORCE    = 3'd5;
	localparam logic [2:0] REG_SQUAT_DONE    = 3'd6;
	localparam logic [2:0] REG_AIR_TARGET    = 3'd7;

	// Fixed gains and targets of the squat and air phases
	localparam logic [15:0] SQUAT_TARGET = 16'd4260;   // 0.065 m
	localparam logic [13:0] SQUAT_K16    = 14'd2400;   // 150 N/m
	localparam logic [11:0] SQUAT_D16    = 12'd192;    // 12 N*s/m
	localparam logic [13:0] AIR_K16      = 14'd1600;   // 100 N/m
	localparam logic [11:0] AIR_D16      = 12'd160;    // 10 N*s/m
	localparam int          HARM_KP      = 5;

	localparam int ACC_W  = 36;   // force accumulator, units of 2^-20 N
	localparam int HARM_W = 30;   // harmony term, same units

	typedef struct packed {
		logic [15:0] air_target_length;
		logic [15:0] squat_done_length;
		logic [14:0] push_force;
		logic [14:0] feedforward_force;
		logic [11:0] normal_damping;
		logic [13:0] normal_stiffness;
		logic [15:0] normal_target_length;
		logic [14:0] force_limit;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		air_target_length:    16'd5243,
		squat_done_length:    16'd4588,
		push_force:           15'd15360,
		feedforward_force:    15'd7168,
		normal_damping:       12'd160,
		normal_stiffness:     14'd960,
		normal_target_length: 16'd6554,
		force_limit:          15'd15360
	};

	typedef struct packed {
		logic signed [15:0] right_angle_rate;
		logic signed [15:0] left_angle_rate;
		logic signed [15:0] right_leg_angle;
		logic signed [15:0] left_leg_angle;
		logic signed [15:0] right_length_rate;
		logic signed [15:0] left_length_rate;
		logic        [15:0] right_length;
		logic        [15:0] left_length;
		logic               touchdown_seen;
		logic               liftoff_seen;
		logic               jump_request;
	} in_item_t;

	typedef struct packed {
		phase_t      phase;
		logic [14:0] right_force;
		logic [14:0] left_force;
	} out_item_t;

endpackage

[rtl/lfj_phase.sv]
module lfj_phase (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  logic             jump_request,
	input  logic             liftoff_seen,
	input  logic             touchdown_seen,
	input  logic [15:0]      left_length,
	input  logic [15:0]      right_length,
	input  logic [15:0]      squat_done_length,
	output lfj_pkg::phase_t  used_phase,
	output lfj_pkg::phase_t  phase_state
);

	lfj_pkg::phase_t phase_q;
	lfj_pkg::phase_t phase_next;

	// Apply events in priority order; touchdown wins
	always_comb begin
		used_phase = phase_q;
		if (jump_request) begin
			used_phase = lfj_pkg::PH_SQUAT;
		end
		if (liftoff_seen && used_phase == lfj_pkg::PH_PUSH) begin
			used_phase = lfj_pkg::PH_AIR;
		end
		if (touchdown_seen) begin
			used_phase = lfj_pkg::PH_NORMAL;
		end
	end

	// Squat ends once both legs are short enough; push starts next item
	always_comb begin
		phase_next = used_phase;
		unique case (used_phase)
			lfj_pkg::PH_SQUAT: begin
				if (left_length < squat_done_length && right_length < squat_done_length) begin
					phase_next = lfj_pkg::PH_PUSH;
				end
			end
			default: phase_next = used_phase;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lfj_pkg::PH_NORMAL;
		end else if (advance) begin
			phase_q <= phase_next;
		end
	end

	assign phase_state = phase_q;

endmodule

[rtl/lfj_leg_force.sv]
module lfj_leg_force (
	input  lfj_pkg::cfg_t                     cfg,
	input  lfj_pkg::phase_t                   phase,
	input  logic [15:0]                       length,
	input  logic signed [15:0]                length_rate,
	input  logic signed [lfj_pkg::HARM_W-1:0] harm,
	output logic [14:0]                       force_out
);

	logic [13:0]                         k16;
	logic [11:0]                         d16;
	logic [15:0]                         target;
	logic signed [16:0]                  len_err;
	logic signed [31:0]                  spring;
	logic signed [28:0]                  damp;
	logic signed [lfj_pkg::ACC_W-1:0]    spring_term;
	logic signed [lfj_pkg::ACC_W-1:0]    damp_term;
	logic signed [lfj_pkg::ACC_W-1:0]    ff_term;
	logic signed [lfj_pkg::ACC_W-1:0]    harm_term;
	logic signed [lfj_pkg::ACC_W-1:0]    push_term;
	logic signed [lfj_pkg::ACC_W-1:0]    acc;
	logic signed [lfj_pkg::ACC_W-1:0]    rnd;
	logic [lfj_pkg::ACC_W-12:0]          q;

	// Pick gains for the phase
	always_comb begin
		case (phase)
			lfj_pkg::PH_SQUAT: begin
				k16    = lfj_pkg::SQUAT_K16;
				d16    = lfj_pkg::SQUAT_D16;
				target = lfj_pkg::SQUAT_TARGET;
			end
			lfj_pkg::PH_AIR: begin
				k16    = lfj_pkg::AIR_K16;
				d16    = lfj_pkg::AIR_D16;
				target = cfg.air_target_length;
			end
			default: begin
				k16    = cfg.normal_stiffness;
				d16    = cfg.normal_damping;
				target = cfg.normal_target_length;
			end
		endcase
	end

	assign len_err = $signed({1'b0, target}) - $signed({1'b0, length});
	assign spring  = $signed({1'b0, k16}) * len_err;
	assign damp    = $signed({1'b0, d16}) * length_rate;

	assign spring_term = lfj_pkg::ACC_W'(spring);
	assign damp_term   = lfj_pkg::ACC_W'(damp) <<< 5;
	assign ff_term     = (phase == lfj_pkg::PH_NORMAL) ?
		$signed(lfj_pkg::ACC_W'({cfg.feedforward_force, 10'b0})) : '0;
	assign harm_term   = (phase == lfj_pkg::PH_AIR) ? lfj_pkg::ACC_W'(harm) : '0;
	assign push_term   = $signed(lfj_pkg::ACC_W'({cfg.push_force, 10'b0}));

	assign acc = (phase == lfj_pkg::PH_PUSH) ? push_term :
		spring_term - damp_term + ff_term + harm_term;

	// Round half up to Q5.10, then clamp to 0..force_limit
	assign rnd = acc + lfj_pkg::ACC_W'(512);
	assign q   = rnd[lfj_pkg::ACC_W-2:10];

	always_comb begin
		if (acc <= 0) begin
			force_out = '0;
		end else if (q > (lfj_pkg::ACC_W-11)'(cfg.force_limit)) begin
			force_out = cfg.force_limit;
		end else begin
			force_out = q[14:0];
		end
	end

endmodule

[rtl/leg_force_jump_controller.sv]
// Leg force jump controller.
//
// Input channel s_*: one item per control tick, carrying the three event
// flags (jump, liftoff, touchdown) and both legs' length, length rate, angle
// and angle rate. Output channel m_*: one item per input item, carrying the
// clamped left and right vertical forces and the phase used for them.
// Configuration: write cfg_wdata into register cfg_index while cfg_we is high;
// write only while the block is idle.
//
// An input register holds the accepted item, one pass of phase logic and
// per-leg spring-damper math (one multiplier per gain) feeds the output
// register, and m_tvalid rises when the output register loads.
// Throughput: one item per cycle while m_tready stays high.
// When the receiver stalls, the output register holds its item and the input
// register still takes one more item; s_tready then drops until the output
// frees up. Nothing is dropped or repeated.
// Reset clears both valid flags, returns the jump phase to normal and loads
// every configuration register with its default.
module leg_force_jump_controller (
	input  logic         clk,
	input  logic         arst_n,
	// item input
	input  logic         s_tvalid,
	output logic         s_tready,
	// [0] jump_request, [1] liftoff_seen, [2] touchdown_seen,
	// [18:3] left_length, [34:19] right_length, [50:35] left_length_rate,
	// [66:51] right_length_rate, [82:67] left_leg_angle, [98:83] right_leg_angle,
	// [114:99] left_angle_rate, [130:115] right_angle_rate, [135:131] unused
	input  logic [135:0] s_tdata,
	// result output
	output logic         m_tvalid,
	input  logic         m_tready,
	// [14:0] left_force, [29:15] right_force, [31:30] phase
	output logic [31:0]  m_tdata,
	// configuration write port
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [15:0]  cfg_wdata
);

	lfj_pkg::cfg_t      cfg_q;
	lfj_pkg::in_item_t  item_s1;
	logic               valid_s1;
	lfj_pkg::out_item_t out_q;
	logic               valid_q;
	logic               out_free;
	logic               advance;
	lfj_pkg::phase_t    used_phase;
	lfj_pkg::phase_t    phase_state;
	logic signed [16:0] ang_diff;
	logic signed [16:0] arate_diff;
	logic signed [lfj_pkg::HARM_W-1:0] harm;
	logic signed [lfj_pkg::HARM_W-1:0] harm_left;
	logic [14:0]        left_force;
	logic [14:0]        right_force;

	// Configuration registers: mask to each register's width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= lfj_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lfj_pkg::REG_FORCE_LIMIT:   cfg_q.force_limit          <= cfg_wdata[14:0];
				lfj_pkg::REG_NORMAL_TARGET: cfg_q.normal_target_length <= cfg_wdata;
				lfj_pkg::REG_NORMAL_STIFF:  cfg_q.normal_stiffness     <= cfg_wdata[13:0];
				lfj_pkg::REG_NORMAL_DAMP:   cfg_q.normal_damping       <= cfg_wdata[11:0];
				lfj_pkg::REG_FEEDFORWARD:   cfg_q.feedforward_force    <= cfg_wdata[14:0];
				lfj_pkg::REG_PUSH_FORCE:    cfg_q.push_force           <= cfg_wdata[14:0];
				lfj_pkg::REG_SQUAT_DONE:    cfg_q.squat_done_length    <= cfg_wdata;
				lfj_pkg::REG_AIR_TARGET:    cfg_q.air_target_length    <= cfg_wdata;
				default:                    cfg_q <= cfg_q;
			endcase
		end
	end

	// Handshake: advance the held item whenever the output register is free
	assign out_free = !valid_q || m_tready;
	assign advance  = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= lfj_pkg::in_item_t'(s_tdata[130:0]);
		end
	end

	lfj_phase u_phase (
		.clk               (clk),
		.arst_n            (arst_n),
		.advance           (advance),
		.jump_request      (item_s1.jump_request),
		.liftoff_seen      (item_s1.liftoff_seen),
		.touchdown_seen    (item_s1.touchdown_seen),
		.left_length       (item_s1.left_length),
		.right_length      (item_s1.right_length),
		.squat_done_length (cfg_q.squat_done_length),
		.used_phase        (used_phase),
		.phase_state       (phase_state)
	);

	// Harmony term: 5 * angle difference * 256 + rate difference * 2048
	assign ang_diff   = 17'(item_s1.left_leg_angle) - 17'(item_s1.right_leg_angle);
	assign arate_diff = 17'(item_s1.left_angle_rate) - 17'(item_s1.right_angle_rate);
	assign harm = ((lfj_pkg::HARM_W'(ang_diff) * lfj_pkg::HARM_W'(lfj_pkg::HARM_KP)) <<< 8)
		+ (lfj_pkg::HARM_W'(arate_diff) <<< 11);
	// Subtract on the left, add on the right
	assign harm_left = -harm;

	lfj_leg_force u_left (
		.cfg         (cfg_q),
		.phase       (used_phase),
		.length      (item_s1.left_length),
		.length_rate (item_s1.left_length_rate),
		.harm        (harm_left),
		.force_out   (left_force)
	);

	lfj_leg_force u_right (
		.cfg         (cfg_q),
		.phase       (used_phase),
		.length      (item_s1.right_length),
		.length_rate (item_s1.right_length_rate),
		.harm        (harm),
		.force_out   (right_force)
	);

	// Output register: hold while the receiver stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.left_force  <= left_force;
			out_q.right_force <= right_force;
			out_q.phase       <= used_phase;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = out_q;

`ifndef ASSERT_OFF
	a_force_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> (out_q.left_force <= $past(cfg_q.force_limit)
			&& out_q.right_force <= $past(cfg_q.force_limit)))
		else $error("force above limit");

	a_push_equal: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && out_q.phase == lfj_pkg::PH_PUSH) |-> out_q.left_force == out_q.right_force)
		else $error("push forces differ");

	a_push_from_squat: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_state == lfj_pkg::PH_PUSH && $past(phase_state) != lfj_pkg::PH_PUSH)
		|-> ($past(used_phase) == lfj_pkg::PH_SQUAT && $past(advance)))
		else $error("push entered without squat");

	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready)
		else $error("empty input stage not ready");
`endif

endmodule
